/* sv/qltb_pkg.sv */
// Shared types and constants for the QoS latency monitor with token-bucket shaper.
// No dependencies; the shaper, the monitor and the top level import this package.
package qltb_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_SIZE    = 3'd4;

  // Register reset values.
  localparam logic [16:0] RST_EMA_WEIGHT    = 17'd6554;
  localparam logic [31:0] RST_LATENCY_LIMIT = 32'd100;
  localparam logic [31:0] RST_JITTER_LIMIT  = 32'd20;
  localparam logic [31:0] RST_REFILL_RATE   = 32'd0;
  localparam logic [31:0] RST_BURST_SIZE    = 32'd0;

  // EMA weight of 1.0 in Q1.16 and the half-LSB used for rounding.
  localparam logic [16:0] EMA_ONE   = 17'h10000;
  localparam logic [15:0] EMA_ROUND = 16'h8000;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_TX   = 2'd1,
    FN_RX   = 2'd2,
    FN_ENQ  = 2'd3
  } func_t;

  typedef struct packed {
    logic [16:0] ema_weight;
    logic [31:0] latency_limit;
    logic [31:0] jitter_limit;
    logic [31:0] refill_rate;
    logic [31:0] burst_size;
  } cfg_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] now_time;
    logic [31:0] byte_count;
  } evt_t;

  typedef struct packed {
    logic        alarm;
    logic [31:0] sequence_res;
    logic [31:0] last_latency;
    logic [31:0] last_jitter;
    logic [47:0] latency_average;
  } mon_res_t;

endpackage

/* sv/qltb_in_if.sv */
// Event request channel: valid/ready handshake carrying one monitor event.
// Standalone; the top level takes the sink side.
interface qltb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_time;
  logic [31:0] byte_count;

  modport source (output valid, func, now_time, byte_count, input ready);
  modport sink   (input valid, func, now_time, byte_count, output ready);
endinterface

/* sv/qltb_out_if.sv */
// Result request channel: valid/ready handshake carrying one status report.
// Standalone; the top level takes the source side.
interface qltb_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               telemetry_valid;
  logic               alarm;
  logic [31:0]        sequence_res;
  logic signed [31:0] last_latency;
  logic [31:0]        last_jitter;
  logic signed [47:0] latency_average;

  modport source (output valid, accepted, telemetry_valid, alarm, sequence_res,
                  last_latency, last_jitter, latency_average, input ready);
  modport sink   (input valid, accepted, telemetry_valid, alarm, sequence_res,
                  last_latency, last_jitter, latency_average, output ready);
endinterface

/* sv/qltb_shaper.sv */
// Token bucket: refill on tick and enqueue, accept or drop enqueue requests.
// Depends on qltb_pkg for the configuration and event types.
module qltb_shaper #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  qltb_pkg::cfg_t  cfg,
  input  logic            burst_wr,
  input  logic [31:0]     burst_data,
  input  logic            fire,
  input  qltb_pkg::evt_t  evt,
  output logic            accepted
);
  import qltb_pkg::*;

  localparam int TW   = 32 + FRAC_BITS;
  localparam int UP   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DOWN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int PW   = 64 + UP;

  logic [TW-1:0] token_level, token_level_next;
  logic [31:0]   refill_time, refill_time_next;
  logic          have_refill_time, have_refill_time_next;

  logic          shaping_on;
  logic          want_refill;
  logic [31:0]   elapsed;
  logic [63:0]   prod;
  logic [PW-1:0] add_w;
  logic [TW-1:0] cap;
  logic [TW-1:0] headroom;
  logic [TW-1:0] level_ref;
  logic [TW-1:0] need;

  assign shaping_on = (cfg.refill_rate != '0) && (cfg.burst_size != '0);
  assign elapsed    = evt.now_time - refill_time;
  assign prod       = 64'(cfg.refill_rate) * 64'(elapsed);
  // Amount scaled to the bucket's fraction bits; only its compare against
  // the headroom matters when it would overflow, so a wider word stands in
  // for saturation.
  assign add_w      = (PW'(prod) << UP) >> DOWN;
  assign cap        = TW'(cfg.burst_size) << FRAC_BITS;
  assign headroom   = cap - token_level;
  assign need       = TW'(evt.byte_count) << FRAC_BITS;

  assign want_refill = shaping_on &&
                       ((evt.func == FN_TICK) ||
                        ((evt.func == FN_ENQ) && (evt.byte_count != '0)));

  always_comb begin
    level_ref = token_level;
    if (!have_refill_time || elapsed == '0) begin
      level_ref = token_level;
    end else if (token_level >= cap || add_w >= PW'(headroom)) begin
      level_ref = cap;
    end else begin
      level_ref = token_level + add_w[TW-1:0];
    end
  end

  always_comb begin
    token_level_next      = token_level;
    refill_time_next      = refill_time;
    have_refill_time_next = have_refill_time;
    accepted              = 1'b0;
    if (want_refill) begin
      token_level_next = level_ref;
      if (!have_refill_time || elapsed != '0) begin
        refill_time_next      = evt.now_time;
        have_refill_time_next = 1'b1;
      end
    end
    if (evt.func == FN_ENQ && evt.byte_count != '0) begin
      if (!shaping_on) begin
        accepted = 1'b1;
      end else if (level_ref >= need) begin
        accepted         = 1'b1;
        token_level_next = level_ref - need;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_level      <= TW'(RST_BURST_SIZE) << FRAC_BITS;
      refill_time      <= '0;
      have_refill_time <= 1'b0;
    end else if (burst_wr) begin
      token_level <= TW'(burst_data) << FRAC_BITS;
    end else if (fire) begin
      token_level      <= token_level_next;
      refill_time      <= refill_time_next;
      have_refill_time <= have_refill_time_next;
    end
  end

endmodule

/* sv/qltb_monitor.sv */
// Latency monitor: transmit stamp, latency, jitter, EMA, timeout, alarm, tick count.
// Depends on qltb_pkg for the configuration, event and report types.
module qltb_monitor #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  qltb_pkg::cfg_t    cfg,
  input  logic              fire,
  input  qltb_pkg::evt_t    evt,
  output qltb_pkg::mon_res_t res
);
  import qltb_pkg::*;

  localparam int AW  = 32 + FRAC_BITS;
  localparam int DW  = AW + 1;
  localparam int MW  = DW - 16;
  localparam int OSR = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int OSL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  logic [31:0]          pending_tx_time, pending_tx_time_next;
  logic                 have_latency, have_latency_next;
  logic [31:0]          latency_reg, latency_reg_next;
  logic [31:0]          jitter_reg, jitter_reg_next;
  logic signed [AW-1:0] average_reg, average_reg_next;
  logic [31:0]          tick_count, tick_count_next;

  logic [31:0]          age;
  logic signed [32:0]   jdiff;
  logic [32:0]          jabs;
  logic [16:0]          w_eff;
  logic signed [DW-1:0] avg_ext, lat_ext, lat_fx, diff, limit_fx, avg_upd;
  logic [DW-1:0]        mag, q;
  logic [MW+16:0]       qhi;
  logic [33:0]          qlo_p;
  logic                 avg_over;
  logic                 alarm;
  logic signed [63:0]   avg_wide, avg_sh;

  assign age     = evt.now_time - pending_tx_time;
  assign jdiff   = 33'($signed(age)) - 33'($signed(latency_reg));
  assign jabs    = jdiff[32] ? 33'(-jdiff) : 33'(jdiff);
  assign w_eff   = (cfg.ema_weight > EMA_ONE) ? EMA_ONE : cfg.ema_weight;

  // EMA step: avg += alpha * (lat - avg), rounded half away from zero on
  // the magnitude of the difference.
  assign avg_ext = DW'(average_reg);
  assign lat_ext = DW'($signed(age));
  assign lat_fx  = lat_ext <<< FRAC_BITS;
  assign diff    = lat_fx - avg_ext;
  assign mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign qhi     = (MW+17)'(mag[DW-1:16]) * (MW+17)'(w_eff);
  assign qlo_p   = 34'(mag[15:0]) * 34'(w_eff) + 34'(EMA_ROUND);
  assign q       = DW'(qhi) + DW'(qlo_p[33:16]);
  assign avg_upd = diff[DW-1] ? (avg_ext - $signed(q)) : (avg_ext + $signed(q));

  assign limit_fx = $signed(DW'(cfg.latency_limit) << FRAC_BITS);
  assign avg_over = avg_ext > limit_fx;

  always_comb begin
    pending_tx_time_next = pending_tx_time;
    have_latency_next    = have_latency;
    latency_reg_next     = latency_reg;
    jitter_reg_next      = jitter_reg;
    average_reg_next     = average_reg;
    tick_count_next      = tick_count;
    alarm                = 1'b0;
    unique case (evt.func)
      FN_TICK: begin
        if (pending_tx_time != '0 && age > cfg.latency_limit) begin
          pending_tx_time_next = '0;
        end
        alarm           = avg_over || (jitter_reg > cfg.jitter_limit);
        tick_count_next = tick_count + 32'd1;
      end
      FN_TX: begin
        pending_tx_time_next = evt.now_time;
      end
      FN_RX: begin
        if (pending_tx_time != '0) begin
          jitter_reg_next      = have_latency ? jabs[31:0] : '0;
          have_latency_next    = 1'b1;
          latency_reg_next     = age;
          average_reg_next     = avg_upd[AW-1:0];
          pending_tx_time_next = '0;
        end
      end
      FN_ENQ: begin
      end
      default: begin
      end
    endcase
  end

  // Report the average with 16 fraction bits, flooring when narrowing.
  assign avg_wide = 64'(average_reg_next);
  assign avg_sh   = (avg_wide >>> OSR) <<< OSL;

  always_comb begin
    res.alarm           = alarm;
    res.sequence_res    = tick_count_next;
    res.last_latency    = latency_reg_next;
    res.last_jitter     = jitter_reg_next;
    res.latency_average = avg_sh[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_tx_time <= '0;
      have_latency    <= 1'b0;
      latency_reg     <= '0;
      jitter_reg      <= '0;
      average_reg     <= '0;
      tick_count      <= '0;
    end else if (fire) begin
      pending_tx_time <= pending_tx_time_next;
      have_latency    <= have_latency_next;
      latency_reg     <= latency_reg_next;
      jitter_reg      <= jitter_reg_next;
      average_reg     <= average_reg_next;
      tick_count      <= tick_count_next;
    end
  end

endmodule

/* sv/qos_latency_monitor_token_bucket.sv */
// QoS latency monitor with token-bucket shaper. The block takes one event per
// clock cycle and returns exactly one report per event; an event register and
// a report register sit on either side of a single pass of update logic (one
// 32x32 refill multiply, one 33x17 and one 16x17 EMA multiply, adds and
// compares), so the sustained rate is one event per cycle and only
// backpressure on the report channel slows it. Configuration writes
// take effect at once and must be made while no event is in flight; writing
// the burst size also reloads the bucket to full. There is no clearing pass.
// Depends on qltb_pkg, qltb_in_if, qltb_out_if, qltb_shaper and qltb_monitor.
module qos_latency_monitor_token_bucket #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qltb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qltb_pkg::CFG_DATA_W-1:0]   cfg_data,
  qltb_in_if.sink                           ingress,
  qltb_out_if.source                        egress
);
  import qltb_pkg::*;

  cfg_t     cfg;
  evt_t     evt;
  logic     evt_valid;
  logic     advance;
  logic     fire;
  logic     burst_wr;
  logic     accepted;
  mon_res_t mon;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ema_weight    <= RST_EMA_WEIGHT;
      cfg.latency_limit <= RST_LATENCY_LIMIT;
      cfg.jitter_limit  <= RST_JITTER_LIMIT;
      cfg.refill_rate   <= RST_REFILL_RATE;
      cfg.burst_size    <= RST_BURST_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EMA_WEIGHT:    cfg.ema_weight    <= cfg_data[16:0];
        CFG_LATENCY_LIMIT: cfg.latency_limit <= cfg_data;
        CFG_JITTER_LIMIT:  cfg.jitter_limit  <= cfg_data;
        CFG_REFILL_RATE:   cfg.refill_rate   <= cfg_data;
        CFG_BURST_SIZE:    cfg.burst_size    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign burst_wr = cfg_we && (cfg_index == CFG_BURST_SIZE);

  // The event register drains whenever the report register is empty or
  // being taken, so a new request can be accepted in the same cycle.
  assign advance       = !egress.valid || egress.ready;
  assign fire          = evt_valid && advance;
  assign ingress.ready = !evt_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (ingress.valid && ingress.ready) begin
      evt_valid <= 1'b1;
    end else if (fire) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ingress.valid && ingress.ready) begin
      evt.func       <= func_t'(ingress.func);
      evt.now_time   <= ingress.now_time;
      evt.byte_count <= ingress.byte_count;
    end
  end

  qltb_shaper #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shaper (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .burst_wr   (burst_wr),
    .burst_data (cfg_data),
    .fire       (fire),
    .evt        (evt),
    .accepted   (accepted)
  );

  qltb_monitor #(
    .FRAC_BITS (FRAC_BITS)
  ) u_monitor (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .evt  (evt),
    .res  (mon)
  );

  // Report register.
  always_ff @(posedge clk) begin
    if (rst) begin
      egress.valid <= 1'b0;
    end else if (advance) begin
      egress.valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      egress.accepted        <= accepted;
      egress.telemetry_valid <= (evt.func == FN_TICK);
      egress.alarm           <= mon.alarm;
      egress.sequence_res    <= mon.sequence_res;
      egress.last_latency    <= $signed(mon.last_latency);
      egress.last_jitter     <= mon.last_jitter;
      egress.latency_average <= $signed(mon.latency_average);
    end
  end

endmodule
